// ===== hdl/cop_pkg.sv =====
// Shared types, register codes and constants for the converter overload protection block.
package cop_pkg;

    localparam int TIMER_WIDTH_DEF = 16;
    localparam int CFG_DATA_W      = 16;
    localparam int CFG_IDX_W       = 3;
    localparam int STATUS_W        = 6;

    // status bit positions
    localparam int ST_ON   = 0;
    localparam int ST_OFF  = 1;
    localparam int ST_OVL  = 2;
    localparam int ST_ADC  = 3;
    localparam int ST_TNE  = 4;
    localparam int ST_UEXP = 5;

    localparam logic [STATUS_W-1:0] STATUS_RESET = STATUS_W'(1) << ST_OFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROT_EN  = 3'd0,
        CFG_TRIP     = 3'd1,
        CFG_BLANK    = 3'd2,
        CFG_MIN_OFF  = 3'd3,
        CFG_USER     = 3'd4,
        CFG_BLINK    = 3'd5,
        CFG_WARN     = 3'd6
    } t_cfg_idx;

    localparam logic [CFG_DATA_W-1:0] TRIP_RESET    = 16'd100;
    localparam logic [CFG_DATA_W-1:0] BLANK_RESET   = 16'd50;
    localparam logic [CFG_DATA_W-1:0] MIN_OFF_RESET = 16'd100;
    localparam logic [CFG_DATA_W-1:0] USER_RESET    = 16'd100;
    localparam logic [CFG_DATA_W-1:0] BLINK_RESET   = 16'd50;
    localparam logic [CFG_DATA_W-1:0] WARN_RESET    = 16'd500;

    typedef struct packed {
        logic                  ovl_check_en;
        logic [CFG_DATA_W-1:0] trip_ticks;
        logic [CFG_DATA_W-1:0] blank_ticks;
        logic [CFG_DATA_W-1:0] min_off_ticks;
        logic [CFG_DATA_W-1:0] user_ticks;
        logic [CFG_DATA_W-1:0] blink_ticks;
        logic [CFG_DATA_W-1:0] warn_ticks;
    } t_cfg;

    typedef struct packed {
        logic overload_pin;
        logic cmd_clear_overload;
        logic cmd_turn_off;
        logic cmd_turn_on;
        logic cmd_user_restart;
        logic cmd_blink_restart;
        logic adc_force_off;
        logic adc_release;
        logic ext_overload_status;
    } t_in_word;

    typedef struct packed {
        logic drive_on;
        logic is_on;
        logic is_off;
        logic is_overloaded;
        logic is_adc_off;
        logic off_time_running;
        logic user_expired;
        logic green_lamp;
        logic led_red;
        logic trip_event;
        logic warn_pulse;
    } t_out_word;

endpackage

// ===== hdl/converter_overload_protection.sv =====
// Top level of the converter overload protection block: config port, tick logic, result register.
//
// One input word is one timer tick and yields exactly one result word. A word is
// taken in every clock cycle while the result register is empty or being drained,
// so the block sustains one tick per cycle; the result is registered and appears in
// the cycle after the word is accepted. The tick logic computes the status bits and
// the six down-counters (TIMER_WIDTH bits each, reload values taken from the low bits
// of the 16-bit registers) combinationally. Configuration writes are taken every cycle
// and are meant to land only while no tick is in flight; writes to index 7 are dropped.
module converter_overload_protection #(
    parameter int TIMER_WIDTH = cop_pkg::TIMER_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  cop_pkg::t_in_word               i_in_word,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output cop_pkg::t_out_word              o_out_word,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [cop_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [cop_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    cop_pkg::t_cfg      cfg;
    cop_pkg::t_out_word tick_word;
    logic               step;

    logic               r_out_valid;
    cop_pkg::t_out_word r_out_word;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign step        = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    cop_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    cop_tick #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_tick (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_word  (i_in_word),
        .i_cfg   (cfg),
        .o_word  (tick_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_word <= tick_word;
        end
    end

    a_on_off_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.is_on ^ o_out_word.is_off))
        else $error("on and off status bits not exclusive");

    a_warn_red: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.warn_pulse) |-> o_out_word.led_red)
        else $error("warning pulse without counted overload");

    a_green_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.green_lamp) |-> o_out_word.is_on)
        else $error("green LED lit while converter not on");

    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");

endmodule

// ===== hdl/cop_cfg_regs.sv =====
// Configuration register file written through the index/data write channel.
module cop_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [cop_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [cop_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output cop_pkg::t_cfg                       o_cfg
);

    cop_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ovl_check_en  <= 1'b1;
            r_cfg.trip_ticks    <= cop_pkg::TRIP_RESET;
            r_cfg.blank_ticks   <= cop_pkg::BLANK_RESET;
            r_cfg.min_off_ticks <= cop_pkg::MIN_OFF_RESET;
            r_cfg.user_ticks    <= cop_pkg::USER_RESET;
            r_cfg.blink_ticks   <= cop_pkg::BLINK_RESET;
            r_cfg.warn_ticks    <= cop_pkg::WARN_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                cop_pkg::CFG_PROT_EN: r_cfg.ovl_check_en  <= i_cfg_data[0];
                cop_pkg::CFG_TRIP:    r_cfg.trip_ticks    <= i_cfg_data;
                cop_pkg::CFG_BLANK:   r_cfg.blank_ticks   <= i_cfg_data;
                cop_pkg::CFG_MIN_OFF: r_cfg.min_off_ticks <= i_cfg_data;
                cop_pkg::CFG_USER:    r_cfg.user_ticks    <= i_cfg_data;
                cop_pkg::CFG_BLINK:   r_cfg.blink_ticks   <= i_cfg_data;
                cop_pkg::CFG_WARN:    r_cfg.warn_ticks    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== hdl/cop_tick.sv =====
// Per-tick state update: status bits, six down-counters and the result word.
module cop_tick #(
    parameter int TIMER_WIDTH = cop_pkg::TIMER_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  cop_pkg::t_in_word   i_word,
    input  cop_pkg::t_cfg       i_cfg,
    output cop_pkg::t_out_word  o_word
);

    localparam logic [TIMER_WIDTH-1:0] ONE = TIMER_WIDTH'(1);

    logic [cop_pkg::STATUS_W-1:0] r_status, n_status;
    logic [TIMER_WIDTH-1:0] r_blank, n_blank;
    logic [TIMER_WIDTH-1:0] r_trip, n_trip;
    logic [TIMER_WIDTH-1:0] r_off, n_off;
    logic [TIMER_WIDTH-1:0] r_user, n_user;
    logic [TIMER_WIDTH-1:0] r_blink, n_blink;
    logic [TIMER_WIDTH-1:0] r_warn, n_warn;

    logic [TIMER_WIDTH-1:0] trip_rl, blank_rl, off_rl, user_rl, blink_rl, warn_rl;

    assign trip_rl  = TIMER_WIDTH'(i_cfg.trip_ticks);
    assign blank_rl = TIMER_WIDTH'(i_cfg.blank_ticks);
    assign off_rl   = TIMER_WIDTH'(i_cfg.min_off_ticks);
    assign user_rl  = TIMER_WIDTH'(i_cfg.user_ticks);
    assign blink_rl = TIMER_WIDTH'(i_cfg.blink_ticks);
    assign warn_rl  = TIMER_WIDTH'(i_cfg.warn_ticks);

    always_comb begin
        logic check;
        logic ovl;
        logic trip;
        logic warn;
        logic green;

        n_status = r_status;
        n_blank  = r_blank;
        n_off    = r_off;
        n_user   = r_user;
        n_blink  = r_blink;
        n_warn   = r_warn;
        check    = 1'b0;
        warn     = 1'b0;

        // blanking after switch-on
        if (r_status[cop_pkg::ST_OFF] || r_status[cop_pkg::ST_ADC]
                || !i_cfg.ovl_check_en) begin
            n_blank = blank_rl;
        end else if (r_blank != '0) begin
            n_blank = r_blank - ONE;
        end else begin
            check = 1'b1;
        end

        ovl = check && i_word.overload_pin;

        if (!ovl) begin
            n_trip = trip_rl;
        end else if (r_trip != '0) begin
            n_trip = r_trip - ONE;
        end else begin
            n_trip = r_trip;
        end

        trip = (n_trip == '0);
        if (trip) begin
            n_status[cop_pkg::ST_ON]  = 1'b0;
            n_status[cop_pkg::ST_OFF] = 1'b1;
            n_status[cop_pkg::ST_OVL] = 1'b1;
            n_off = off_rl;
        end

        if (i_word.cmd_clear_overload) begin
            n_status[cop_pkg::ST_OVL] = 1'b0;
        end
        if (i_word.cmd_turn_off && !n_status[cop_pkg::ST_OFF]) begin
            n_status[cop_pkg::ST_ON]  = 1'b0;
            n_status[cop_pkg::ST_OFF] = 1'b1;
            n_off = off_rl;
        end else if (i_word.cmd_turn_on && !n_status[cop_pkg::ST_ON]) begin
            n_status[cop_pkg::ST_OFF] = 1'b0;
            n_status[cop_pkg::ST_ON]  = 1'b1;
        end
        if (i_word.cmd_user_restart) begin
            n_user = user_rl;
        end
        if (i_word.cmd_blink_restart) begin
            n_blink = blink_rl;
        end

        if (i_word.adc_force_off) begin
            n_status[cop_pkg::ST_ADC] = 1'b1;
        end else if (i_word.adc_release) begin
            n_status[cop_pkg::ST_ADC] = 1'b0;
        end

        green = n_status[cop_pkg::ST_ON] && (n_blink == '0);

        if (ovl && (r_warn == '0)) begin
            warn   = 1'b1;
            n_warn = warn_rl;
        end

        // count down timers
        if (n_off != '0) begin
            n_off = n_off - ONE;
            n_status[cop_pkg::ST_TNE] = 1'b1;
        end else begin
            n_status[cop_pkg::ST_TNE] = 1'b0;
        end
        if (n_user != '0) begin
            n_user = n_user - ONE;
            n_status[cop_pkg::ST_UEXP] = 1'b0;
        end else begin
            n_status[cop_pkg::ST_UEXP] = 1'b1;
        end
        if (n_blink != '0) begin
            n_blink = n_blink - ONE;
        end
        if (n_warn != '0) begin
            n_warn = n_warn - ONE;
        end

        o_word.drive_on         = n_status[cop_pkg::ST_ON] && !n_status[cop_pkg::ST_OFF]
                                  && !n_status[cop_pkg::ST_ADC];
        o_word.is_on            = n_status[cop_pkg::ST_ON];
        o_word.is_off           = n_status[cop_pkg::ST_OFF];
        o_word.is_overloaded    = n_status[cop_pkg::ST_OVL];
        o_word.is_adc_off       = n_status[cop_pkg::ST_ADC];
        o_word.off_time_running = n_status[cop_pkg::ST_TNE];
        o_word.user_expired     = n_status[cop_pkg::ST_UEXP];
        o_word.green_lamp       = green;
        o_word.led_red          = ovl || i_word.ext_overload_status;
        o_word.trip_event       = trip;
        o_word.warn_pulse       = warn;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status <= cop_pkg::STATUS_RESET;
            r_blank  <= '0;
            r_trip   <= '0;
            r_off    <= '0;
            r_user   <= '0;
            r_blink  <= '0;
            r_warn   <= '0;
        end else if (i_step) begin
            r_status <= n_status;
            r_blank  <= n_blank;
            r_trip   <= n_trip;
            r_off    <= n_off;
            r_user   <= n_user;
            r_blink  <= n_blink;
            r_warn   <= n_warn;
        end
    end

endmodule
